// ===== hw/rtl/lnwd_pkg.sv =====
`default_nettype none

package lnwd_pkg;

    typedef enum logic [1:0] {
        OP_CMD  = 2'd0,
        OP_DATA = 2'd1,
        OP_NUM  = 2'd2
    } t_op;

    localparam int unsigned DEF_FIFO_DEPTH = 4;
    localparam int unsigned NUM_DIGITS     = 5;
    localparam int unsigned DIGIT_IDX_W    = $clog2(NUM_DIGITS);
    localparam int unsigned REST_W         = 17;
    localparam logic [7:0]  DIGIT_BASE     = 8'h30;

    typedef struct packed {
        logic [7:0] data;
        logic       reg_select;
        logic       last;
    } t_entry;

    function automatic logic [REST_W-1:0] digit_multiple(input logic [DIGIT_IDX_W-1:0] idx,
                                                         input logic [3:0] k);
        logic [REST_W-1:0] m;
        case (idx)
            3'd0:    m = REST_W'(int'(k) * 10000);
            3'd1:    m = REST_W'(int'(k) * 1000);
            3'd2:    m = REST_W'(int'(k) * 100);
            3'd3:    m = REST_W'(int'(k) * 10);
            3'd4:    m = REST_W'(int'(k));
            default: m = REST_W'(int'(k));
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lnwd_in_if.sv =====
`default_nettype none

interface lnwd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [15:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lnwd_out_if.sv =====
`default_nettype none

interface lnwd_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] nibble;
    logic       reg_select;
    logic       last;

    modport source (output valid, output nibble, output reg_select, output last, input ready);
    modport sink   (input valid, input nibble, input reg_select, input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lnwd_front.sv =====
`default_nettype none

module lnwd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    lnwd_in_if.sink            i_in,
    output logic               o_push,
    output lnwd_pkg::t_entry   o_entry,
    input  logic               i_push_ready
);

    logic                                 r_busy, n_busy;
    logic [lnwd_pkg::DIGIT_IDX_W-1:0]     r_idx, n_idx;
    logic [lnwd_pkg::REST_W-1:0]          r_rest, n_rest;

    logic                                 accept;
    logic [lnwd_pkg::REST_W-1:0]          thr;
    logic [lnwd_pkg::REST_W-1:0]          sub;
    logic [3:0]                           digit;

    assign i_in.ready = !r_busy && i_push_ready;
    assign accept     = i_in.valid && i_in.ready;

    // compare against each multiple of the weight, keep the largest that fits
    always_comb begin
        digit = 4'd0;
        sub   = '0;
        thr   = '0;
        for (int k = 1; k < 10; k++) begin
            thr = lnwd_pkg::digit_multiple(r_idx, 4'(k));
            if (r_rest >= thr) begin
                digit = 4'(k);
                sub   = thr;
            end
        end
    end

    always_comb begin
        n_busy  = r_busy;
        n_idx   = r_idx;
        n_rest  = r_rest;
        o_push  = 1'b0;
        o_entry = '0;
        if (r_busy) begin
            o_entry.data       = lnwd_pkg::DIGIT_BASE + {4'd0, digit};
            o_entry.reg_select = 1'b1;
            o_entry.last       = (r_idx == lnwd_pkg::DIGIT_IDX_W'(lnwd_pkg::NUM_DIGITS - 1));
            if (i_push_ready) begin
                o_push = 1'b1;
                n_rest = r_rest - sub;
                n_idx  = r_idx + 1'b1;
                if (o_entry.last) begin
                    n_busy = 1'b0;
                end
            end
        end else if (accept) begin
            case (i_in.op)
                lnwd_pkg::OP_CMD, lnwd_pkg::OP_DATA: begin
                    o_push             = 1'b1;
                    o_entry.data       = i_in.value[7:0];
                    o_entry.reg_select = (i_in.op == lnwd_pkg::OP_DATA);
                    o_entry.last       = 1'b1;
                end
                lnwd_pkg::OP_NUM: begin
                    n_busy = 1'b1;
                    n_idx  = '0;
                    n_rest = {1'b0, i_in.value};
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
        r_rest <= n_rest;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lnwd_fifo.sv =====
`default_nettype none

module lnwd_fifo #(
    parameter int unsigned DEPTH = lnwd_pkg::DEF_FIFO_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  lnwd_pkg::t_entry   i_entry,
    output logic               o_push_ready,
    output logic               o_pop_valid,
    output lnwd_pkg::t_entry   o_entry,
    input  logic               i_pop
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    lnwd_pkg::t_entry  r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              do_push, do_pop;

    assign o_push_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_entry      = r_mem[r_rd];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!do_push && do_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lnwd_back.sv =====
`default_nettype none

module lnwd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_pop_valid,
    input  lnwd_pkg::t_entry   i_entry,
    output logic               o_pop,
    lnwd_out_if.source         o_out
);

    logic       r_valid, n_valid;
    logic       r_lo, n_lo;
    logic [3:0] r_nibble, n_nibble;
    logic       r_rs, n_rs;
    logic       r_last, n_last;
    logic       load;

    assign load = !r_valid || o_out.ready;

    always_comb begin
        n_valid  = r_valid;
        n_lo     = r_lo;
        n_nibble = r_nibble;
        n_rs     = r_rs;
        n_last   = r_last;
        o_pop    = 1'b0;
        if (load) begin
            n_valid = i_pop_valid;
            if (i_pop_valid) begin
                n_nibble = r_lo ? i_entry.data[3:0] : i_entry.data[7:4];
                n_rs     = i_entry.reg_select;
                n_last   = r_lo && i_entry.last;
                n_lo     = !r_lo;
                o_pop    = r_lo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_lo    <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_lo    <= n_lo;
        end
        r_nibble <= n_nibble;
        r_rs     <= n_rs;
        r_last   <= n_last;
    end

    assign o_out.valid      = r_valid;
    assign o_out.nibble     = r_nibble;
    assign o_out.reg_select = r_rs;
    assign o_out.last       = r_last;

endmodule

`default_nettype wire

// ===== hw/rtl/lcd_nibble_writer_with_decimal.sv =====
// Channel  Dir  Fields                         Transfer
// i_in     in   op[1:0], value[15:0]           valid & ready
// o_out    out  nibble[3:0], reg_select, last  valid & ready
//
// Nibbles leave one per cycle while o_out is ready: two per byte, ten per number.
// The output register sets that pace; the front yields a byte per cycle while the
// queue has room, loads each number first and finds digits by compares to weights.
// Reset clears the queue, the nibble phase and the output valid; no clearing pass.
// A stalled output fills the queue, and then the input stops taking items.
`default_nettype none

module lcd_nibble_writer_with_decimal #(
    parameter int unsigned FIFO_DEPTH = lnwd_pkg::DEF_FIFO_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lnwd_in_if.sink      i_in,
    lnwd_out_if.source   o_out
);

    logic              push, push_ready, pop, pop_valid;
    lnwd_pkg::t_entry  push_entry, pop_entry;

    lnwd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push       (push),
        .o_entry      (push_entry),
        .i_push_ready (push_ready)
    );

    lnwd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_entry      (push_entry),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_entry      (pop_entry),
        .i_pop        (pop)
    );

    lnwd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_entry     (pop_entry),
        .o_pop       (pop),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

// ===== sim/tb_lcd_nibble_writer_with_decimal.sv =====
`default_nettype none

module tb_lcd_nibble_writer_with_decimal;
    timeunit 1ns;
    timeprecision 1ps;

    import lnwd_pkg::*;

    typedef struct {
        logic [1:0]  op;
        logic [15:0] value;
        int unsigned gap;
        bit          wait_idle;
    } t_lcd_req;

    typedef struct {
        logic [3:0] nibble;
        logic       reg_select;
        logic       last;
    } t_lcd_xfer;

    localparam int unsigned IDLE_MAX = 14;
    localparam logic [1:0]  OP_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lnwd_in_if  u_in_if ();
    lnwd_out_if u_out_if ();

    lcd_nibble_writer_with_decimal u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u_in_if),
        .o_out   (u_out_if)
    );

    t_lcd_req    pending_reqs[$];
    t_lcd_xfer   expected_xfers[$];
    int unsigned total_reqs = 0;
    int unsigned taken_reqs = 0;
    int unsigned bad_xfers = 0;
    int unsigned gap_max = IDLE_MAX;
    int unsigned stall_max = IDLE_MAX;
    int unsigned stall_left = 0;
    int unsigned xfers_seen = 0;
    logic        in_xfer = 1'b0;
    logic        out_xfer = 1'b0;

    always #5 i_clk = ~i_clk;

    function automatic void push_byte(input logic [7:0] data, input logic rs,
                                      input logic fin);
        t_lcd_xfer x;
        x.nibble     = data[7:4];
        x.reg_select = rs;
        x.last       = 1'b0;
        expected_xfers.push_back(x);
        x.nibble     = data[3:0];
        x.last       = fin;
        expected_xfers.push_back(x);
    endfunction

    function automatic void predict_lcd_writes(input logic [1:0] op, input logic [15:0] value);
        int unsigned weights[5];
        int unsigned rest;
        int unsigned digit;
        weights = '{10000, 1000, 100, 10, 1};
        rest = value;
        case (op)
            OP_CMD:  push_byte(value[7:0], 1'b0, 1'b1);
            OP_DATA: push_byte(value[7:0], 1'b1, 1'b1);
            OP_NUM: begin
                for (int i = 0; i < NUM_DIGITS; i++) begin
                    digit = rest / weights[i];
                    rest  = rest % weights[i];
                    push_byte(DIGIT_BASE + 8'(digit), 1'b1, i == NUM_DIGITS - 1);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void add_req(input logic [1:0] op, input logic [15:0] value,
                                    input bit wait_idle);
        t_lcd_req r;
        r.op        = op;
        r.value     = value;
        r.gap       = $urandom_range(0, gap_max);
        r.wait_idle = wait_idle;
        pending_reqs.push_back(r);
        total_reqs++;
    endfunction

    function automatic logic [15:0] rand_value();
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0:       v = 16'hFFFF;
            1:       v = 16'h0000;
            2:       v = 16'($urandom_range(0, 99));
            3:       v = 16'($urandom_range(59990, 65535));
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    always @(posedge i_clk) begin
        in_xfer  <= i_rst_n && u_in_if.valid && u_in_if.ready;
        out_xfer <= i_rst_n && u_out_if.valid && u_out_if.ready;
        if (i_rst_n && u_in_if.valid && u_in_if.ready) begin
            predict_lcd_writes(u_in_if.op, u_in_if.value);
            taken_reqs++;
        end
        if (i_rst_n && u_out_if.valid && u_out_if.ready) begin
            if (expected_xfers.size() == 0) begin
                $error("unexpected transfer: nibble %h reg_select %b last %b",
                       u_out_if.nibble, u_out_if.reg_select, u_out_if.last);
                bad_xfers++;
            end else begin
                t_lcd_xfer x;
                x = expected_xfers.pop_front();
                if (u_out_if.nibble !== x.nibble) begin
                    $error("nibble: expected %h, actual %h", x.nibble, u_out_if.nibble);
                    bad_xfers++;
                end
                if (u_out_if.reg_select !== x.reg_select) begin
                    $error("reg_select: expected %b, actual %b",
                           x.reg_select, u_out_if.reg_select);
                    bad_xfers++;
                end
                if (u_out_if.last !== x.last) begin
                    $error("last: expected %b, actual %b", x.last, u_out_if.last);
                    bad_xfers++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            u_in_if.valid <= 1'b0;
        end else if (u_in_if.valid && !in_xfer) begin
            u_in_if.valid <= 1'b1;
        end else if (pending_reqs.size() == 0) begin
            u_in_if.valid <= 1'b0;
        end else if (pending_reqs[0].gap > 0) begin
            pending_reqs[0].gap--;
            u_in_if.valid <= 1'b0;
        end else if (pending_reqs[0].wait_idle && expected_xfers.size() != 0) begin
            u_in_if.valid <= 1'b0;
        end else begin
            t_lcd_req r;
            r = pending_reqs.pop_front();
            u_in_if.op    <= r.op;
            u_in_if.value <= r.value;
            u_in_if.valid <= 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            u_out_if.ready <= 1'b0;
        end else if (out_xfer) begin
            xfers_seen++;
            if (xfers_seen % 32 == 0)
                stall_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
            stall_left = $urandom_range(0, stall_max);
            u_out_if.ready <= (stall_left == 0);
        end else if (stall_left > 0) begin
            stall_left--;
            u_out_if.ready <= (stall_left == 0);
        end else begin
            u_out_if.ready <= 1'b1;
        end
    end

    initial begin
        int unsigned n_valid;
        logic [1:0]  op;
        bit          quiet;
        i_rst_n        = 1'b0;
        u_in_if.valid  = 1'b0;
        u_in_if.op     = 2'd0;
        u_in_if.value  = 16'd0;
        u_out_if.ready = 1'b0;

        add_req(OP_CMD,    16'h0000, 1'b0);
        add_req(OP_CMD,    16'h00FF, 1'b0);
        add_req(OP_CMD,    16'hFF5A, 1'b0);
        add_req(OP_DATA,   16'h0000, 1'b0);
        add_req(OP_DATA,   16'h00FF, 1'b0);
        add_req(OP_DATA,   16'hABA5, 1'b0);
        add_req(OP_UNUSED, 16'h0000, 1'b0);
        add_req(OP_UNUSED, 16'hFFFF, 1'b0);
        add_req(OP_NUM,    16'd0,    1'b0);
        add_req(OP_NUM,    16'd65535, 1'b0);
        add_req(OP_NUM,    16'd1,    1'b0);
        add_req(OP_NUM,    16'd9,    1'b0);
        add_req(OP_NUM,    16'd10,   1'b0);
        add_req(OP_NUM,    16'd9999, 1'b1);
        add_req(OP_NUM,    16'd10000, 1'b0);
        add_req(OP_NUM,    16'd12345, 1'b0);
        add_req(OP_NUM,    16'd59999, 1'b0);
        add_req(OP_NUM,    16'd60000, 1'b0);
        add_req(OP_UNUSED, 16'h1234, 1'b0);
        add_req(OP_DATA,   16'h5500, 1'b0);

        n_valid = 0;
        quiet = 1'b0;
        while (n_valid < 350) begin
            if (n_valid % 40 == 0) begin
                quiet = ($urandom_range(0, 3) == 0);
                gap_max = quiet ? 0 : IDLE_MAX;
            end
            case ($urandom_range(0, 19))
                0:           op = OP_UNUSED;
                1, 2, 3, 4:  op = OP_CMD;
                5, 6, 7, 8:  op = OP_DATA;
                default:     op = OP_NUM;
            endcase
            add_req(op, rand_value(), $urandom_range(0, 60) == 0);
            if (op != OP_UNUSED)
                n_valid++;
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (taken_reqs == total_reqs);
        wait (expected_xfers.size() == 0);
        repeat (30) @(posedge i_clk);
        if (bad_xfers == 0 && expected_xfers.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
